// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the point density histogram.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/pdh_pkg.sv -----
// Types and constants for the point density histogram.
package pdh_pkg;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_INDEX,
		ST_READ,
		ST_UPDATE
	} pdh_state_t;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
	localparam logic [2:0] REG_SCALE_X      = 3'd2;
	localparam logic [2:0] REG_SCALE_Y      = 3'd3;
	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;

	// Request kinds on tuser
	localparam logic REQ_PLOT = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam int COUNT_W = 32;
	localparam int COORD_W = 32;
	localparam int SIZE_W  = 11;
	localparam int PIX_W   = 10;
	localparam int IDX_W   = 24;  // integer part of the Q24.40 product
	localparam int EXT_W   = 13;  // holds any size up to 4096

	localparam logic [31:0] SCALE_ONE = 32'h0001_0000;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

// ----- rtl/core/point_density_histogram.sv -----
// Point density histogram: maps points to pixels and counts hits per bin.
//
// Each transaction on the input stream either plots a point (origin subtracted,
// scaled by a Q16.16 pixels-per-unit factor, floored and clamped to the image)
// or reads one bin. Every transaction returns one result: the pixel, the bin
// count after the increment (or the value read) and the highest count so far.
// Bins live in one synchronous memory of MAX_HEIGHT rows by 2**clog2(MAX_WIDTH)
// columns; an item goes accept, multiply, clamp, memory read, then update and
// write back. The block takes no new item until the last one has finished its
// update, as the state machine runs this read-modify-write sequence around the
// bin memory one item at a time, and the update waits while an earlier result
// is still untaken. After reset a clearing pass writes zero to every memory
// entry, one per cycle, during which no item is accepted; register writes are
// taken throughout. The output register lets a new item be accepted while a
// result waits to be taken.
`include "assert_macros.svh"

module point_density_histogram #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// point_x[31:0], point_y[63:32], read_col[73:64], read_row[83:74], zero pad
	input  logic [87:0] s_axis_tdata,
	// req_type
	input  logic        s_axis_tuser,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel_col[9:0], pixel_row[19:10], bin_count[51:20], max_count[83:52], zero pad
	output logic [87:0] m_axis_tdata
);

	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int RW        = $clog2(MAX_HEIGHT);
	localparam int AW        = CW + RW;
	localparam int MEM_DEPTH = MAX_HEIGHT * (1 << CW);
	localparam int SZW_X     = $clog2(MAX_WIDTH + 1);
	localparam int SZW_Y     = $clog2(MAX_HEIGHT + 1);

	localparam int CNT_W = pdh_pkg::COUNT_W;

	// configuration
	logic [31:0]                origin_x_q, origin_y_q, scale_x_q, scale_y_q;
	logic [pdh_pkg::SIZE_W-1:0] image_width_q, image_height_q;
	logic                       cfg_wr;

	pdh_pkg::pdh_state_t state_q, state_d;

	logic [AW-1:0]    clr_addr_q;
	logic             clr_last;
	logic [CNT_W-1:0] peak_q;
	logic             out_valid_q;

	// pipeline
	logic                        req_s1;
	logic [32:0]                 diff_x_s1, diff_y_s1;
	logic [pdh_pkg::PIX_W-1:0]   rcol_s1, rrow_s1;
	logic [63:0]                 prod_x_s2, prod_y_s2;
	logic                        neg_x_s2, neg_y_s2;
	logic [CW-1:0]               col_s3;
	logic [RW-1:0]               row_s3;
	logic [CNT_W-1:0]            rd_data_s4;

	logic [CNT_W-1:0] bin_mem [MEM_DEPTH];

	logic [pdh_pkg::PIX_W-1:0] out_col_q, out_row_q;
	logic [CNT_W-1:0]          out_count_q, out_peak_q;

	logic                  accept, done, plot_wr, mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [CNT_W-1:0]      mem_wdata, count_inc, new_count, new_peak;
	logic [SZW_X-1:0]      w_use;
	logic [SZW_Y-1:0]      h_use;
	logic [pdh_pkg::EXT_W-1:0] w_ext, h_ext;
	logic [pdh_pkg::IDX_W-1:0] lim_x, lim_y, cand_x, cand_y, cl_x, cl_y;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			scale_x_q      <= pdh_pkg::SCALE_ONE;
			scale_y_q      <= pdh_pkg::SCALE_ONE;
			image_width_q  <= pdh_pkg::SIZE_W'(1024);
			image_height_q <= pdh_pkg::SIZE_W'(1024);
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				pdh_pkg::REG_ORIGIN_X:     origin_x_q     <= pwdata;
				pdh_pkg::REG_ORIGIN_Y:     origin_y_q     <= pwdata;
				pdh_pkg::REG_SCALE_X:      scale_x_q      <= pwdata;
				pdh_pkg::REG_SCALE_Y:      scale_y_q      <= pwdata;
				pdh_pkg::REG_IMAGE_WIDTH:  image_width_q  <= pwdata[pdh_pkg::SIZE_W-1:0];
				pdh_pkg::REG_IMAGE_HEIGHT: image_height_q <= pwdata[pdh_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			pdh_pkg::REG_ORIGIN_X:     prdata = origin_x_q;
			pdh_pkg::REG_ORIGIN_Y:     prdata = origin_y_q;
			pdh_pkg::REG_SCALE_X:      prdata = scale_x_q;
			pdh_pkg::REG_SCALE_Y:      prdata = scale_y_q;
			pdh_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width_q);
			pdh_pkg::REG_IMAGE_HEIGHT: prdata = 32'(image_height_q);
			default:                   prdata = '0;
		endcase
	end

	// sizes in use: zero acts as one, oversize clamps to the maximum
	always_comb begin
		w_ext = pdh_pkg::EXT_W'(image_width_q);
		h_ext = pdh_pkg::EXT_W'(image_height_q);
		if (image_width_q == '0)
			w_use = SZW_X'(1);
		else if (w_ext > pdh_pkg::EXT_W'(MAX_WIDTH))
			w_use = SZW_X'(MAX_WIDTH);
		else
			w_use = SZW_X'(image_width_q);
		if (image_height_q == '0)
			h_use = SZW_Y'(1);
		else if (h_ext > pdh_pkg::EXT_W'(MAX_HEIGHT))
			h_use = SZW_Y'(MAX_HEIGHT);
		else
			h_use = SZW_Y'(image_height_q);
	end

	// ---------------- control ----------------
	assign s_axis_tready = (state_q == pdh_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign done          = (state_q == pdh_pkg::ST_UPDATE) && (!out_valid_q || m_axis_tready);
	assign clr_last      = (clr_addr_q == AW'(MEM_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pdh_pkg::ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pdh_pkg::ST_CLEAR:  if (clr_last) state_d = pdh_pkg::ST_IDLE;
			pdh_pkg::ST_IDLE:   if (accept) state_d = pdh_pkg::ST_MUL;
			pdh_pkg::ST_MUL:    state_d = pdh_pkg::ST_INDEX;
			pdh_pkg::ST_INDEX:  state_d = pdh_pkg::ST_READ;
			pdh_pkg::ST_READ:   state_d = pdh_pkg::ST_UPDATE;
			pdh_pkg::ST_UPDATE: if (done) state_d = pdh_pkg::ST_IDLE;
			default:            state_d = pdh_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == pdh_pkg::ST_CLEAR)
				clr_addr_q <= clr_addr_q + AW'(1);
			if (done)
				peak_q <= new_peak;
			if (done)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// ---------------- datapath ----------------
	// clamp to size-1; negative offsets land on pixel zero
	always_comb begin
		lim_x  = pdh_pkg::IDX_W'(w_use) - pdh_pkg::IDX_W'(1);
		lim_y  = pdh_pkg::IDX_W'(h_use) - pdh_pkg::IDX_W'(1);
		cand_x = (req_s1 == pdh_pkg::REQ_READ) ? pdh_pkg::IDX_W'(rcol_s1) :
		         (neg_x_s2 ? '0 : prod_x_s2[63:40]);
		cand_y = (req_s1 == pdh_pkg::REQ_READ) ? pdh_pkg::IDX_W'(rrow_s1) :
		         (neg_y_s2 ? '0 : prod_y_s2[63:40]);
		cl_x   = (cand_x > lim_x) ? lim_x : cand_x;
		cl_y   = (cand_y > lim_y) ? lim_y : cand_y;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1    <= s_axis_tuser;
			diff_x_s1 <= {s_axis_tdata[31], s_axis_tdata[31:0]} - {origin_x_q[31], origin_x_q};
			diff_y_s1 <= {s_axis_tdata[63], s_axis_tdata[63:32]} - {origin_y_q[31], origin_y_q};
			rcol_s1   <= s_axis_tdata[73:64];
			rrow_s1   <= s_axis_tdata[83:74];
		end
		if (state_q == pdh_pkg::ST_MUL) begin
			prod_x_s2 <= 64'(diff_x_s1[31:0]) * 64'(scale_x_q);
			prod_y_s2 <= 64'(diff_y_s1[31:0]) * 64'(scale_y_q);
			neg_x_s2  <= diff_x_s1[32];
			neg_y_s2  <= diff_y_s1[32];
		end
		if (state_q == pdh_pkg::ST_INDEX) begin
			col_s3 <= cl_x[CW-1:0];
			row_s3 <= cl_y[RW-1:0];
		end
	end

	// bin update
	always_comb begin
		count_inc = (rd_data_s4 == pdh_pkg::COUNT_MAX) ? rd_data_s4 : rd_data_s4 + CNT_W'(1);
		plot_wr   = done && (req_s1 == pdh_pkg::REQ_PLOT);
		new_count = (req_s1 == pdh_pkg::REQ_PLOT) ? count_inc : rd_data_s4;
		new_peak  = ((req_s1 == pdh_pkg::REQ_PLOT) && (count_inc > peak_q)) ? count_inc : peak_q;
		mem_we    = (state_q == pdh_pkg::ST_CLEAR) || plot_wr;
		mem_waddr = (state_q == pdh_pkg::ST_CLEAR) ? clr_addr_q : {row_s3, col_s3};
		mem_wdata = (state_q == pdh_pkg::ST_CLEAR) ? '0 : count_inc;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			bin_mem[mem_waddr] <= mem_wdata;
		if (state_q == pdh_pkg::ST_READ)
			rd_data_s4 <= bin_mem[{row_s3, col_s3}];
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_col_q   <= pdh_pkg::PIX_W'(col_s3);
			out_row_q   <= pdh_pkg::PIX_W'(row_s3);
			out_count_q <= new_count;
			out_peak_q  <= new_peak;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_peak_q, out_count_q, out_row_q, out_col_q};

	// ---------------- assertions ----------------
	`ASSERT_NEXT(a_peak_monotonic, clk, arst_n, state_q != pdh_pkg::ST_CLEAR, peak_q >= $past(peak_q), "peak count decreased")
	`ASSERT_IMPLIES(a_count_below_peak, clk, arst_n, out_valid_q, out_count_q <= out_peak_q, "bin count above peak")
	`ASSERT_IMPLIES(a_no_result_in_clear, clk, arst_n, state_q == pdh_pkg::ST_CLEAR, !out_valid_q && !mem_we || mem_waddr == clr_addr_q, "activity during clearing pass")

endmodule
